### design/vsids_pkg.sv
// ----------------------------------------------------------------------------
// VSIDS activity table package
// Shared widths, opcodes, register indexes, reset values and beat types of
// the activity table.
// ----------------------------------------------------------------------------
package vsids_pkg;

  // Field widths.
  localparam int OPCODE_W = 2;
  localparam int VAR_W    = 10;
  localparam int AMOUNT_W = 20;
  localparam int SCORE_W  = 31;
  localparam int TOTAL_W  = 32;
  localparam int COUNT_W  = 8;
  localparam int NUMER_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // Default table depth.
  localparam int TABLE_DEPTH_DEF = 1024;

  // Opcodes.
  localparam logic [OPCODE_W-1:0] OP_BUMP     = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CONFLICT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY    = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_CLEAR    = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_PERIOD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_NUMERATOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_THRESHOLD   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_LIMIT     = 2'd3;

  // Register reset values.
  localparam logic [COUNT_W-1:0] DECAY_PERIOD_RST    = 8'd2;
  localparam logic [NUMER_W-1:0] DECAY_NUMERATOR_RST = 8'd230;
  localparam logic [SCORE_W-1:0] DIR_THRESHOLD_RST   = 31'd32;
  localparam logic [SCORE_W-1:0] SCORE_LIMIT_RST     = 31'h4000_0000;

  // Largest score; a bump saturates here.
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  // What a table-wide sweep writes back.
  typedef enum logic [1:0] {
    SW_ZERO  = 2'd0,
    SW_SHIFT = 2'd1,
    SW_DECAY = 2'd2
  } sweep_mode_t;

  // One table entry: both polarity scores of a variable.
  typedef struct packed {
    logic [SCORE_W-1:0] t_score;
    logic [SCORE_W-1:0] f_score;
  } score_pair_t;

  // Input beat.
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [VAR_W-1:0]    var_index;
    logic [AMOUNT_W-1:0] bump_amount;
    logic                polarity;
    logic                preferred_direction;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic               chosen_direction;
    logic [TOTAL_W-1:0] total_score;
    logic               table_rescaled;
  } out_item_t;

endpackage

### design/vsids_activity_table_top.sv
// ----------------------------------------------------------------------------
// VSIDS activity table
// Per-variable true/false activity scores in one synchronous memory, with
// bump, conflict-driven decay, direction query and table clear.
// ----------------------------------------------------------------------------
// Sequence: a query, a conflict without decay or a bump out of range goes
// from the lookup state to the result state; any other bump writes its entry
// back in between. Busy stays high until the result strobe. A rescaling bump,
// a decaying conflict and a clear add a table sweep and a reread of the entry.
// The block takes one operation at a time. Reset runs a clearing pass of the
// table with busy high; the receiver cannot stall.
module vsids_activity_table_top
  import vsids_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_valid,
  output out_item_t             out_item,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > VAR_W) ? CNT_W : VAR_W;
  localparam int PROD_W = SCORE_W + NUMER_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOOK   = 6'b000010,
    S_BUMP   = 6'b000100,
    S_SWEEP  = 6'b001000,
    S_REREAD = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  // Control registers.
  state_t             state_r, state_nxt;
  sweep_mode_t        sw_mode_r, sw_mode_nxt;
  logic               sw_report_r, sw_report_nxt;
  logic [CNT_W-1:0]   sw_cnt_r, sw_cnt_nxt;
  logic               sw_wr_vld_r, sw_wr_vld_nxt;
  logic               resc_r, resc_nxt;
  logic               decay_hit_r, decay_hit_nxt;
  logic               swept_r, swept_nxt;
  logic [COUNT_W-1:0] countdown_r, countdown_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Configuration registers.
  logic [COUNT_W-1:0] period_r, period_nxt;
  logic [NUMER_W-1:0] numer_r, numer_nxt;
  logic [SCORE_W-1:0] thresh_r, thresh_nxt;
  logic [SCORE_W-1:0] limit_r, limit_nxt;

  // Payload registers.
  in_item_t           item_r, item_nxt;
  logic [SCORE_W-1:0] t_r, t_nxt;
  logic [SCORE_W-1:0] f_r, f_nxt;
  logic [ADDR_W-1:0]  sw_wr_addr_r, sw_wr_addr_nxt;
  out_item_t          out_item_r, out_item_nxt;

  // Memory and its ports.
  score_pair_t        mem [TABLE_DEPTH];
  score_pair_t        mem_q_r;
  logic               mem_rd_en;
  logic [ADDR_W-1:0]  mem_rd_addr;
  logic               mem_wr_en;
  logic [ADDR_W-1:0]  mem_wr_addr;
  score_pair_t        mem_wr_data;

  // Datapath helpers.
  logic [CMP_W-1:0]   in_idx_ext;
  logic [CMP_W-1:0]   item_idx_ext;
  logic [ADDR_W-1:0]  in_addr;
  logic [ADDR_W-1:0]  item_addr;
  logic               item_valid;
  logic [COUNT_W-1:0] cd_dec;
  logic [SCORE_W-1:0] bump_old;
  logic [TOTAL_W-1:0] bump_sum;
  logic [SCORE_W-1:0] bump_new;
  logic [SCORE_W-1:0] bumped;
  logic               sw_rd_done;
  logic [PROD_W-1:0]  t_prod;
  logic [PROD_W-1:0]  f_prod;
  logic [TOTAL_W-1:0] f_plus_thr;
  logic [TOTAL_W-1:0] t_plus_thr;
  logic               query_dir;

  // Index range check and memory address of the incoming and held beats.
  assign in_idx_ext   = CMP_W'(in_item.var_index);
  assign item_idx_ext = CMP_W'(item_r.var_index);
  assign in_addr      = in_idx_ext[ADDR_W-1:0];
  assign item_addr    = item_idx_ext[ADDR_W-1:0];
  assign item_valid   = item_idx_ext < CMP_W'(TABLE_DEPTH);

  // Conflict countdown step, wrapping modulo 256.
  assign cd_dec = countdown_r - COUNT_W'(1);

  // Saturating bump of the chosen polarity score.
  assign bump_old = item_r.polarity ? mem_q_r.t_score : mem_q_r.f_score;
  assign bump_sum = TOTAL_W'(bump_old) + TOTAL_W'(item_r.bump_amount);
  assign bump_new = bump_sum[SCORE_W] ? SCORE_MAX : bump_sum[SCORE_W-1:0];
  assign bumped   = item_r.polarity ? t_r : f_r;

  // Sweep read pointer has passed the last entry.
  assign sw_rd_done = (sw_cnt_r == CNT_W'(TABLE_DEPTH));

  // Decay multiply on the registered read data.
  assign t_prod = PROD_W'(mem_q_r.t_score) * PROD_W'(numer_r);
  assign f_prod = PROD_W'(mem_q_r.f_score) * PROD_W'(numer_r);

  // Direction: true when t - f > threshold, false when f - t > threshold.
  assign f_plus_thr = TOTAL_W'(f_r) + TOTAL_W'(thresh_r);
  assign t_plus_thr = TOTAL_W'(t_r) + TOTAL_W'(thresh_r);
  always_comb begin
    if (TOTAL_W'(t_r) > f_plus_thr) begin
      query_dir = 1'b1;
    end else if (TOTAL_W'(f_r) > t_plus_thr) begin
      query_dir = 1'b0;
    end else begin
      query_dir = item_r.preferred_direction;
    end
  end

  // Sequencer and memory port control.
  always_comb begin
    state_nxt      = state_r;
    sw_mode_nxt    = sw_mode_r;
    sw_report_nxt  = sw_report_r;
    sw_cnt_nxt     = sw_cnt_r;
    sw_wr_vld_nxt  = sw_wr_vld_r;
    sw_wr_addr_nxt = sw_wr_addr_r;
    resc_nxt       = resc_r;
    decay_hit_nxt  = decay_hit_r;
    swept_nxt      = swept_r;
    countdown_nxt  = countdown_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;
    item_nxt       = item_r;
    t_nxt          = t_r;
    f_nxt          = f_r;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = item_addr;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = item_addr;
    mem_wr_data    = '{t_score: t_r, f_score: f_r};

    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt      = in_item;
          mem_rd_en     = 1'b1;
          mem_rd_addr   = in_addr;
          resc_nxt      = 1'b0;
          swept_nxt     = 1'b0;
          decay_hit_nxt = 1'b0;
          if (in_item.opcode == OP_CONFLICT) begin
            if (cd_dec == '0) begin
              countdown_nxt = period_r;
              decay_hit_nxt = 1'b1;
            end else begin
              countdown_nxt = cd_dec;
            end
          end else if (in_item.opcode == OP_CLEAR) begin
            countdown_nxt = period_r;
          end
          state_nxt = S_LOOK;
        end
      end

      S_LOOK: begin
        // Entry data is back; an index out of range reads as zero.
        t_nxt = item_valid ? mem_q_r.t_score : '0;
        f_nxt = item_valid ? mem_q_r.f_score : '0;
        state_nxt = S_DONE;
        if (!swept_r) begin
          case (item_r.opcode)
            OP_BUMP: begin
              if (item_valid) begin
                if (item_r.polarity) begin
                  t_nxt = bump_new;
                end else begin
                  f_nxt = bump_new;
                end
                state_nxt = S_BUMP;
              end
            end
            OP_CONFLICT: begin
              if (decay_hit_r) begin
                resc_nxt      = 1'b1;
                sw_mode_nxt   = SW_DECAY;
                sw_report_nxt = 1'b1;
                sw_cnt_nxt    = '0;
                sw_wr_vld_nxt = 1'b0;
                state_nxt     = S_SWEEP;
              end
            end
            OP_CLEAR: begin
              sw_mode_nxt   = SW_ZERO;
              sw_report_nxt = 1'b1;
              sw_cnt_nxt    = '0;
              sw_wr_vld_nxt = 1'b0;
              state_nxt     = S_SWEEP;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_BUMP: begin
        // Write the bumped entry back, then shift the table when the score passes the limit.
        mem_wr_en = 1'b1;
        if (bumped > limit_r) begin
          resc_nxt      = 1'b1;
          sw_mode_nxt   = SW_SHIFT;
          sw_report_nxt = 1'b1;
          sw_cnt_nxt    = '0;
          sw_wr_vld_nxt = 1'b0;
          state_nxt     = S_SWEEP;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_SWEEP: begin
        // Read entry n while entry n - 1 is written back.
        if (!sw_rd_done) begin
          mem_rd_en      = 1'b1;
          mem_rd_addr    = sw_cnt_r[ADDR_W-1:0];
          sw_wr_addr_nxt = sw_cnt_r[ADDR_W-1:0];
          sw_cnt_nxt     = sw_cnt_r + CNT_W'(1);
          sw_wr_vld_nxt  = 1'b1;
        end else begin
          sw_wr_vld_nxt = 1'b0;
        end
        if (sw_wr_vld_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = sw_wr_addr_r;
          case (sw_mode_r)
            SW_SHIFT: begin
              mem_wr_data = '{t_score: mem_q_r.t_score >> 2,
                              f_score: mem_q_r.f_score >> 2};
            end
            SW_DECAY: begin
              mem_wr_data = '{t_score: t_prod[PROD_W-1:NUMER_W],
                              f_score: f_prod[PROD_W-1:NUMER_W]};
            end
            default: begin
              mem_wr_data = '0;
            end
          endcase
        end
        if (sw_rd_done && !sw_wr_vld_r) begin
          state_nxt = sw_report_r ? S_REREAD : S_IDLE;
        end
      end

      S_REREAD: begin
        // Fetch the addressed entry again after the table changed.
        mem_rd_en = 1'b1;
        swept_nxt = 1'b1;
        state_nxt = S_LOOK;
      end

      S_DONE: begin
        out_valid_nxt                 = 1'b1;
        out_item_nxt.chosen_direction = (item_r.opcode == OP_QUERY) ? query_dir : 1'b0;
        out_item_nxt.total_score      = TOTAL_W'(t_r) + TOTAL_W'(f_r);
        out_item_nxt.table_rescaled   = resc_r;
        state_nxt                     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Configuration writes.
  always_comb begin
    period_nxt = period_r;
    numer_nxt  = numer_r;
    thresh_nxt = thresh_r;
    limit_nxt  = limit_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DECAY_PERIOD:    period_nxt = cfg_wdata[COUNT_W-1:0];
        CFG_DECAY_NUMERATOR: numer_nxt  = cfg_wdata[NUMER_W-1:0];
        CFG_DIR_THRESHOLD:   thresh_nxt = cfg_wdata[SCORE_W-1:0];
        CFG_SCORE_LIMIT:     limit_nxt  = cfg_wdata[SCORE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control state; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sw_mode_r   <= SW_ZERO;
      sw_report_r <= 1'b0;
      sw_cnt_r    <= '0;
      sw_wr_vld_r <= 1'b0;
      resc_r      <= 1'b0;
      decay_hit_r <= 1'b0;
      swept_r     <= 1'b0;
      countdown_r <= DECAY_PERIOD_RST;
      out_valid_r <= 1'b0;
      period_r    <= DECAY_PERIOD_RST;
      numer_r     <= DECAY_NUMERATOR_RST;
      thresh_r    <= DIR_THRESHOLD_RST;
      limit_r     <= SCORE_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      sw_mode_r   <= sw_mode_nxt;
      sw_report_r <= sw_report_nxt;
      sw_cnt_r    <= sw_cnt_nxt;
      sw_wr_vld_r <= sw_wr_vld_nxt;
      resc_r      <= resc_nxt;
      decay_hit_r <= decay_hit_nxt;
      swept_r     <= swept_nxt;
      countdown_r <= countdown_nxt;
      out_valid_r <= out_valid_nxt;
      period_r    <= period_nxt;
      numer_r     <= numer_nxt;
      thresh_r    <= thresh_nxt;
      limit_r     <= limit_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    t_r          <= t_nxt;
    f_r          <= f_nxt;
    sw_wr_addr_r <= sw_wr_addr_nxt;
    out_item_r   <= out_item_nxt;
  end

  // Score memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd_en) begin
      mem_q_r <= mem[mem_rd_addr];
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### verif/tb_vsids_activity_table_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// VSIDS activity table testbench
// Drives command beats into the activity table and checks every result beat
// against a local score table predictor. Directed tests cover each opcode,
// the direction threshold edges, limit rescaling, saturation and a zero
// decay period. Random traffic then runs under several register settings
// with sender idling and a full drain in the middle of each setting.
// ----------------------------------------------------------------------------
module tb_vsids_activity_table_top;
  import vsids_pkg::*;

  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int DECAY_SHIFT = 8;
  localparam int TAIL_CYCLES = 2 * TABLE_DEPTH_DEF + 20;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_item;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Predicted table, countdown and register copies.
  logic [SCORE_W-1:0] score_true  [TABLE_DEPTH_DEF];
  logic [SCORE_W-1:0] score_false [TABLE_DEPTH_DEF];
  logic [COUNT_W-1:0] countdown;
  logic [COUNT_W-1:0] cfg_period;
  logic [NUMER_W-1:0] cfg_numerator;
  logic [SCORE_W-1:0] cfg_threshold;
  logic [SCORE_W-1:0] cfg_limit;

  out_item_t expected_results [$];
  int        error_count;
  int        cycle_count;
  int        result_count;
  int        sender_idle_pct;

  vsids_activity_table_top #(
    .TABLE_DEPTH (TABLE_DEPTH_DEF)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Free-running clock, 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 100) begin
      $display("MISMATCH cycle %0d result %0d: %s", cycle_count, result_count, msg);
    end
  endtask

  // Rewrite every entry of the predicted table.
  task automatic sweep_scores(input sweep_mode_t mode);
    logic [SCORE_W+NUMER_W-1:0] prod;
    for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
      case (mode)
        SW_ZERO: begin
          score_true[i]  = '0;
          score_false[i] = '0;
        end
        SW_SHIFT: begin
          score_true[i]  = score_true[i] >> 2;
          score_false[i] = score_false[i] >> 2;
        end
        default: begin
          prod = (SCORE_W+NUMER_W)'(score_true[i]) * (SCORE_W+NUMER_W)'(cfg_numerator);
          score_true[i] = prod[DECAY_SHIFT +: SCORE_W];
          prod = (SCORE_W+NUMER_W)'(score_false[i]) * (SCORE_W+NUMER_W)'(cfg_numerator);
          score_false[i] = prod[DECAY_SHIFT +: SCORE_W];
        end
      endcase
    end
  endtask

  // Apply one command beat to the predicted table and form its result beat.
  task automatic apply_activity_op(input in_item_t it, output out_item_t res);
    logic [SCORE_W:0]          sum;
    logic [SCORE_W-1:0]        t_val;
    logic [SCORE_W-1:0]        f_val;
    logic signed [SCORE_W+1:0] diff;
    logic signed [SCORE_W+1:0] thr;
    res = '0;
    case (it.opcode)
      OP_BUMP: begin
        sum = it.polarity ? {1'b0, score_true[it.var_index]}
                          : {1'b0, score_false[it.var_index]};
        sum = sum + (SCORE_W+1)'(it.bump_amount);
        if (sum > {1'b0, SCORE_MAX}) sum = {1'b0, SCORE_MAX};
        if (it.polarity) score_true[it.var_index] = sum[SCORE_W-1:0];
        else score_false[it.var_index] = sum[SCORE_W-1:0];
        if (sum[SCORE_W-1:0] > cfg_limit) begin
          sweep_scores(SW_SHIFT);
          res.table_rescaled = 1'b1;
        end
      end
      OP_CONFLICT: begin
        countdown = countdown - 1'b1;
        if (countdown == '0) begin
          sweep_scores(SW_DECAY);
          countdown = cfg_period;
          res.table_rescaled = 1'b1;
        end
      end
      OP_CLEAR: begin
        sweep_scores(SW_ZERO);
        countdown = cfg_period;
      end
      default: ;
    endcase
    t_val = score_true[it.var_index];
    f_val = score_false[it.var_index];
    // The direction follows the score gap only when it clears the threshold.
    if (it.opcode == OP_QUERY) begin
      diff = $signed({2'b00, t_val}) - $signed({2'b00, f_val});
      thr  = $signed({2'b00, cfg_threshold});
      if (diff > thr) res.chosen_direction = 1'b1;
      else if (diff < -thr) res.chosen_direction = 1'b0;
      else res.chosen_direction = it.preferred_direction;
    end
    res.total_score = TOTAL_W'(t_val) + TOTAL_W'(f_val);
  endtask

  // Lower start and wait until the block has returned every result beat.
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0 || busy) @(posedge clk);
  endtask

  // Register write, only issued while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_DECAY_PERIOD:    cfg_period    = data[COUNT_W-1:0];
      CFG_DECAY_NUMERATOR: cfg_numerator = data[NUMER_W-1:0];
      CFG_DIR_THRESHOLD:   cfg_threshold = data[SCORE_W-1:0];
      default:             cfg_limit     = data[SCORE_W-1:0];
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_all_regs(input logic [CFG_DATA_W-1:0] period,
                                input logic [CFG_DATA_W-1:0] numer,
                                input logic [CFG_DATA_W-1:0] thr,
                                input logic [CFG_DATA_W-1:0] limit);
    write_reg(CFG_DECAY_PERIOD, period);
    write_reg(CFG_DECAY_NUMERATOR, numer);
    write_reg(CFG_DIR_THRESHOLD, thr);
    write_reg(CFG_SCORE_LIMIT, limit);
  endtask

  // Send one command beat, with a random gap in front of it, and record the
  // expected result once the block takes it.
  task automatic send_item(input in_item_t it);
    int        gap;
    out_item_t res;
    gap = 0;
    while (gap < 50 && $urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    apply_activity_op(it, res);
    expected_results.insert(expected_results.size(), res);
  endtask

  task automatic send_op(input logic [OPCODE_W-1:0] op, input int idx,
                         input int amount, input bit pol, input bit pref);
    in_item_t it;
    it.opcode              = op;
    it.var_index           = VAR_W'(idx);
    it.bump_amount         = AMOUNT_W'(amount);
    it.polarity            = pol;
    it.preferred_direction = pref;
    send_item(it);
  endtask

  // Each result beat is checked against the oldest expectation.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid) begin
      result_count++;
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with no expectation pending");
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (out_item.chosen_direction !== want.chosen_direction)
          report_mismatch($sformatf("chosen_direction got %0b expected %0b",
                                    out_item.chosen_direction, want.chosen_direction));
        if (out_item.total_score !== want.total_score)
          report_mismatch($sformatf("total_score got %0d expected %0d",
                                    out_item.total_score, want.total_score));
        if (out_item.table_rescaled !== want.table_rescaled)
          report_mismatch($sformatf("table_rescaled got %0b expected %0b",
                                    out_item.table_rescaled, want.table_rescaled));
      end
    end
  end

  // Each opcode, field extremes, threshold edges, decay and limit rescale.
  task automatic test_directed_ops();
    sender_idle_pct = 10;
    send_op(OP_QUERY, 0, 0, 1'b0, 1'b1);
    send_op(OP_QUERY, 1023, 0, 1'b1, 1'b0);
    send_op(OP_BUMP, 5, 100, 1'b1, 1'b0);
    send_op(OP_BUMP, 5, 68, 1'b0, 1'b1);
    // A gap equal to the threshold leaves the caller's preference.
    send_op(OP_QUERY, 5, 0, 1'b0, 1'b0);
    send_op(OP_QUERY, 5, 0, 1'b0, 1'b1);
    send_op(OP_BUMP, 5, 1, 1'b1, 1'b0);
    send_op(OP_QUERY, 5, 0, 1'b1, 1'b0);
    send_op(OP_BUMP, 6, 20'hF_FFFF, 1'b0, 1'b0);
    send_op(OP_BUMP, 6, 0, 1'b1, 1'b1);
    send_op(OP_QUERY, 6, 20'hF_FFFF, 1'b1, 1'b1);
    send_op(OP_BUMP, 1023, 20'hF_FFFF, 1'b1, 1'b1);
    // Two conflicts with the reset period trigger a decay.
    send_op(OP_CONFLICT, 5, 0, 1'b0, 1'b0);
    send_op(OP_CONFLICT, 1023, 20'hF_FFFF, 1'b1, 1'b1);
    send_op(OP_QUERY, 5, 0, 1'b0, 1'b1);
    send_op(OP_CLEAR, 1023, 0, 1'b0, 1'b0);
    send_op(OP_QUERY, 1023, 0, 1'b0, 1'b1);
    // A bump equal to the limit keeps the table; one more rescales it.
    write_reg(CFG_SCORE_LIMIT, CFG_DATA_W'(1000));
    send_op(OP_BUMP, 3, 1000, 1'b0, 1'b0);
    send_op(OP_BUMP, 3, 1, 1'b0, 1'b0);
    send_op(OP_QUERY, 3, 0, 1'b0, 1'b0);
    write_reg(CFG_SCORE_LIMIT, CFG_DATA_W'(SCORE_LIMIT_RST));
  endtask

  // With a zero limit any bump that leaves a nonzero score rescales.
  task automatic test_zero_score_limit();
    write_reg(CFG_SCORE_LIMIT, '0);
    send_op(OP_CLEAR, 0, 0, 1'b0, 1'b0);
    send_op(OP_BUMP, 2, 0, 1'b1, 1'b0);
    send_op(OP_BUMP, 2, 5, 1'b0, 1'b0);
    send_op(OP_QUERY, 2, 0, 1'b0, 1'b1);
    write_reg(CFG_SCORE_LIMIT, CFG_DATA_W'(SCORE_LIMIT_RST));
  endtask

  // Repeated full-size bumps saturate a score at its largest value.
  task automatic test_score_saturation();
    sender_idle_pct = 0;
    write_reg(CFG_SCORE_LIMIT, CFG_DATA_W'(SCORE_MAX));
    send_op(OP_CLEAR, 0, 0, 1'b0, 1'b0);
    for (int i = 0; i < 2050; i++) send_op(OP_BUMP, 1023, 20'hF_FFFF, 1'b1, 1'b0);
    send_op(OP_BUMP, 1023, 20'hF_FFFF, 1'b0, 1'b0);
    send_op(OP_QUERY, 1023, 0, 1'b0, 1'b0);
    // A saturated score still passes a limit just below the maximum.
    write_reg(CFG_SCORE_LIMIT, CFG_DATA_W'(SCORE_MAX - 1));
    send_op(OP_BUMP, 1023, 1, 1'b1, 1'b0);
    write_reg(CFG_SCORE_LIMIT, CFG_DATA_W'(SCORE_LIMIT_RST));
  endtask

  // A zero period reloads a zero countdown, so a decay takes 256 conflicts.
  task automatic test_zero_decay_period();
    sender_idle_pct = 0;
    write_reg(CFG_DECAY_PERIOD, '0);
    send_op(OP_CLEAR, 0, 0, 1'b0, 1'b0);
    send_op(OP_BUMP, 9, 1000, 1'b1, 1'b0);
    for (int i = 0; i < 257; i++) send_op(OP_CONFLICT, 9, 0, 1'b0, 1'b0);
    send_op(OP_QUERY, 9, 0, 1'b0, 1'b0);
    write_reg(CFG_DECAY_PERIOD, CFG_DATA_W'(DECAY_PERIOD_RST));
  endtask

  // Random beats focused on a few variables so that scores grow; the sender
  // drains the block halfway through.
  task automatic run_random_chunk(input int n_items, input int idle_pct);
    in_item_t    it;
    int          sel;
    logic [31:0] rnd;
    sender_idle_pct = idle_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) wait_idle();
      sel = $urandom_range(0, 99);
      if (sel < 45) it.opcode = OP_BUMP;
      else if (sel < 65) it.opcode = OP_CONFLICT;
      else if (sel < 95) it.opcode = OP_QUERY;
      else it.opcode = OP_CLEAR;
      sel = $urandom_range(0, 99);
      rnd = $urandom;
      if (sel < 60) it.var_index = VAR_W'($urandom_range(0, 7));
      else if (sel < 70) it.var_index = rnd[0] ? '1 : '0;
      else it.var_index = rnd[VAR_W-1:0];
      sel = $urandom_range(0, 99);
      rnd = $urandom;
      if (sel < 50) it.bump_amount = rnd[AMOUNT_W-1:0];
      else if (sel < 80) it.bump_amount = AMOUNT_W'($urandom_range(0, 255));
      else it.bump_amount = '1;
      rnd = $urandom;
      it.polarity            = rnd[0];
      it.preferred_direction = rnd[1];
      send_item(it);
    end
  endtask

  // Random traffic over several register settings, extremes included.
  task automatic test_random_traffic();
    write_all_regs(CFG_DATA_W'(DECAY_PERIOD_RST), CFG_DATA_W'(DECAY_NUMERATOR_RST),
                   CFG_DATA_W'(DIR_THRESHOLD_RST), CFG_DATA_W'(SCORE_LIMIT_RST));
    run_random_chunk(250, 10);
    write_all_regs(CFG_DATA_W'(255), CFG_DATA_W'(255), '0, CFG_DATA_W'(SCORE_MAX));
    run_random_chunk(200, 60);
    write_all_regs(CFG_DATA_W'(1), '0, CFG_DATA_W'(31'h4000_0000), CFG_DATA_W'(1));
    run_random_chunk(60, 60);
    write_all_regs('0, CFG_DATA_W'(128), CFG_DATA_W'($urandom_range(0, 1 << 20)),
                   CFG_DATA_W'($urandom_range(1 << 20, 1 << 30)));
    run_random_chunk(250, 0);
    // Full-width data, beyond the usual ranges.
    write_all_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                   CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
    run_random_chunk(240, 0);
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_item         = '0;
    cfg_wr_en       = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    error_count     = 0;
    result_count    = 0;
    sender_idle_pct = 0;
    cfg_period      = DECAY_PERIOD_RST;
    cfg_numerator   = DECAY_NUMERATOR_RST;
    cfg_threshold   = DIR_THRESHOLD_RST;
    cfg_limit       = SCORE_LIMIT_RST;
    countdown       = DECAY_PERIOD_RST;
    sweep_scores(SW_ZERO);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_ops();
    test_zero_score_limit();
    test_score_saturation();
    test_zero_decay_period();
    test_random_traffic();

    // Drain, then watch for stray result beats.
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
design/vsids_pkg.sv
design/vsids_activity_table_top.sv
verif/tb_vsids_activity_table_top.sv
